[rtl/lbp_pkg.sv]
// shared types, constants and the pattern function of the 3x3 lbp block
package lbp_pkg;

	localparam int MAX_WIDTH = 2048;
	localparam int ADDR_W    = $clog2(MAX_WIDTH);
	localparam int WID_W     = 12;
	localparam int ROW_W     = 16;
	localparam int CFG_W     = 16;
	localparam int IDX_W     = 1;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

	// register indexes
	localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	// request kinds
	localparam logic ACT_PIXEL = 1'b0;
	localparam logic ACT_DRAIN = 1'b1;

	localparam logic [WID_W-1:0] WIDTH_RESET  = WID_W'(640);
	localparam logic [ROW_W-1:0] HEIGHT_RESET = ROW_W'(480);
	localparam logic [WID_W-1:0] WIDTH_MIN    = WID_W'(2);
	localparam logic [WID_W-1:0] WIDTH_MAX    = WID_W'(MAX_WIDTH);
	localparam logic [ROW_W-1:0] HEIGHT_MIN   = ROW_W'(2);

	// bt.601 gray weights, 14 bit fixed point
	localparam int GRAY_SUM_W = 22;
	localparam logic [13:0] K_BLUE  = 14'd1868;
	localparam logic [13:0] K_GREEN = 14'd9617;
	localparam logic [13:0] K_RED   = 14'd4899;
	localparam logic [GRAY_SUM_W-1:0] K_ROUND = GRAY_SUM_W'(8192);

	typedef struct packed {
		logic       eob;
		logic       eoi;
		logic [7:0] code;
	} result_t;

	typedef struct packed {
		logic    v0;
		result_t r0;
		logic    v1;
		result_t r1;
	} push_t;

	// column word: top in [23:16], middle in [15:8], bottom in [7:0]
	function automatic logic [7:0] lbp_code(logic [23:0] l, logic [23:0] c, logic [23:0] r);
		logic [7:0] ctr;
		logic [7:0] code;
		ctr = c[15:8];
		code[0] = l[23:16] >= ctr;
		code[1] = c[23:16] >= ctr;
		code[2] = r[23:16] >= ctr;
		code[3] = r[15:8]  >= ctr;
		code[4] = r[7:0]   >= ctr;
		code[5] = c[7:0]   >= ctr;
		code[6] = l[7:0]   >= ctr;
		code[7] = l[15:8]  >= ctr;
		return code;
	endfunction

endpackage

[rtl/lbp_ram.sv]
// generic single write port ram with registered read
module lbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, holds its data while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/lbp_out_fifo.sv]
// small result queue that takes up to two results a cycle and drives the output stream
module lbp_out_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  lbp_pkg::push_t  push,
	output logic            room,
	output logic            out_valid,
	input  logic            out_ready,
	output lbp_pkg::result_t out_data
);

	import lbp_pkg::*;

	result_t                mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]  wp_q;
	logic [FIFO_PTR_W-1:0]  rp_q;
	logic [FIFO_CNT_W-1:0]  cnt_q;
	logic [FIFO_PTR_W-1:0]  wp1;
	logic                   pop;
	logic [FIFO_CNT_W-1:0]  n_push;

	assign pop       = out_valid & out_ready;
	assign wp1       = push.v0 ? wp_q + FIFO_PTR_W'(1) : wp_q;
	assign n_push    = FIFO_CNT_W'(push.v0) + FIFO_CNT_W'(push.v1);
	assign out_valid = cnt_q != '0;
	assign out_data  = mem_q[rp_q];
	// space for a two result request, without counting this cycle's pop
	assign room      = cnt_q <= FIFO_CNT_W'(FIFO_DEPTH - 2);

	// storage
	always_ff @(posedge clk) begin
		if (push.v0) begin
			mem_q[wp_q] <= push.r0;
		end
		if (push.v1) begin
			mem_q[wp1] <= push.r1;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + FIFO_PTR_W'(n_push);
			if (pop) begin
				rp_q <= rp_q + FIFO_PTR_W'(1);
			end
			cnt_q <= cnt_q + n_push - FIFO_CNT_W'(pop);
		end
	end

endmodule

[rtl/lbp_3x3_pixel_stream.sv]
// top level of the 3x3 local binary pattern block over a bgr pixel stream
//
// Input stream s_*: one request per pixel in raster order (s_tuser low) or a
// drain request (s_tuser high) once all rows of the image have arrived.
// Output stream m_*: 8-bit pattern codes; m_tlast marks the final
// code of the image, m_tuser the last code caused by a request.
// A pixel of row r produces the codes of row r-1 (two codes at the row end, none
// in row 0 or column 0); drain request d produces the code of column d of the last row.
// Pixels past the last row and drains before it are taken and dropped.
// Throughput is one request per cycle while the four entry result queue is at most
// half full; any request in stage 1 is held while the queue is fuller than that.
// The line store is read at the accepting edge, as the request enters stage 1;
// the code is pushed into the queue when stage 1 fires, which raises m_tvalid.
// Reset sets width 640 and height 480 and clears counters, window and queue; the
// line stores are not cleared. A register write via cfg_* restarts the image.
// When m_tready is low, results collect in the queue and s_tready drops once the
// queue has no room for two more.
module lbp_3x3_pixel_stream (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [23:0]                   s_tdata,   // blue, green, red
	input  logic                          s_tuser,   // action
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [7:0]                    m_tdata,   // pattern_code
	output logic                          m_tlast,   // end_of_image
	output logic                          m_tuser,   // end_of_burst
	input  logic                          cfg_we,
	input  logic [lbp_pkg::IDX_W-1:0]     cfg_index,
	input  logic [lbp_pkg::CFG_W-1:0]     cfg_data
);

	import lbp_pkg::*;

	// configuration and front counters
	logic [WID_W-1:0]  width_q;
	logic [ROW_W-1:0]  height_q;
	logic [ROW_W-1:0]  row_q;
	logic [ADDR_W-1:0] col_q;
	logic [ADDR_W-1:0] drn_q;

	// stage 1
	logic                  valid_s1;
	logic                  drain_s1;
	logic [ADDR_W-1:0]     addr_s1;
	logic [7:0]            gray_s1;
	logic                  row1_s1;
	logic                  emit_s1;
	logic                  c1_s1;
	logic                  c0_s1;
	logic                  last_s1;
	logic                  d0_s1;
	logic                  byp_s1;
	logic [15:0]           bypd_s1;

	// window and drain columns
	logic [23:0] win0_q, win1_q, win2_q;
	logic [15:0] dprev_q, dcur_q, col0_q;

	logic [WID_W-1:0]      w_eff;
	logic [ADDR_W-1:0]     wm1, wm2;
	logic [ROW_W-1:0]      h_eff;
	logic                  in_acc, is_drain, all_rows, pix_ok, drn_ok;
	logic [ADDR_W-1:0]     c, d, rd_addr;
	logic                  lastcol, dlast;
	logic [GRAY_SUM_W-1:0] gray_sum;
	logic                  fire, room, wr_en;
	logic [15:0]           rd_data, line_word, wr_data;
	logic [7:0]            o, n, top;
	logic [23:0]           newcol, dright, dleft, dcenter;
	logic [15:0]           dcenter16;
	logic [7:0]            code_a, code_b, code_d;
	push_t                 push;
	result_t               head;

	// effective image size
	always_comb begin
		w_eff = width_q;
		if (width_q < WIDTH_MIN) begin
			w_eff = WIDTH_MIN;
		end else if (width_q > WIDTH_MAX) begin
			w_eff = WIDTH_MAX;
		end
		h_eff = (height_q < HEIGHT_MIN) ? HEIGHT_MIN : height_q;
	end
	assign wm1 = ADDR_W'(w_eff - WID_W'(1));
	assign wm2 = ADDR_W'(w_eff - WID_W'(2));

	// request decode and line store address
	assign s_tready = !valid_s1 || fire;
	assign in_acc   = s_tvalid && s_tready;
	assign is_drain = s_tuser == ACT_DRAIN;
	assign all_rows = row_q >= h_eff;
	assign pix_ok   = !is_drain && !all_rows;
	assign drn_ok   = is_drain && all_rows;
	assign c        = ({1'b0, col_q} >= w_eff) ? wm1 : col_q;
	assign d        = ({1'b0, drn_q} >= w_eff) ? wm1 : drn_q;
	assign lastcol  = c == wm1;
	assign dlast    = d == wm1;
	assign rd_addr  = is_drain ? (dlast ? wm2 : d + ADDR_W'(1)) : c;

	// gray conversion
	assign gray_sum = GRAY_SUM_W'(s_tdata[7:0]) * GRAY_SUM_W'(K_BLUE)
		+ GRAY_SUM_W'(s_tdata[15:8]) * GRAY_SUM_W'(K_GREEN)
		+ GRAY_SUM_W'(s_tdata[23:16]) * GRAY_SUM_W'(K_RED) + K_ROUND;

	// configuration registers and front counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			row_q    <= '0;
			col_q    <= '0;
			drn_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH: width_q <= cfg_data[WID_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data[ROW_W-1:0];
				default: ;
			endcase
			row_q <= '0;
			col_q <= '0;
			drn_q <= '0;
		end else if (in_acc) begin
			if (pix_ok) begin
				if (lastcol) begin
					col_q <= '0;
					row_q <= row_q + ROW_W'(1);
				end else begin
					col_q <= c + ADDR_W'(1);
				end
			end else if (drn_ok) begin
				if (dlast) begin
					row_q <= '0;
					col_q <= '0;
					drn_q <= '0;
				end else begin
					drn_q <= d + ADDR_W'(1);
				end
			end
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= pix_ok || drn_ok;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage 1 payload, plus forwarding of a write to the address being read
	always_ff @(posedge clk) begin
		if (in_acc) begin
			drain_s1 <= is_drain;
			addr_s1  <= rd_addr;
			gray_s1  <= gray_sum[GRAY_SUM_W-1:14];
			row1_s1  <= row_q == ROW_W'(1);
			emit_s1  <= (row_q != '0) && (c != '0);
			c1_s1    <= c == ADDR_W'(1);
			c0_s1    <= c == '0;
			last_s1  <= is_drain ? dlast : lastcol;
			d0_s1    <= d == '0;
			byp_s1   <= wr_en && (addr_s1 == rd_addr);
			bypd_s1  <= wr_data;
		end
	end

	// line stores: older row in [15:8], newer row in [7:0]
	lbp_ram #(
		.WIDTH(16),
		.DEPTH(MAX_WIDTH)
	) u_line (
		.clk  (clk),
		.we   (wr_en),
		.waddr(addr_s1),
		.wdata(wr_data),
		.re   (in_acc),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	// stage 1 datapath
	assign fire      = valid_s1 && room;
	assign wr_en     = fire && !drain_s1;
	assign line_word = byp_s1 ? bypd_s1 : rd_data;
	assign o         = line_word[15:8];
	assign n         = line_word[7:0];
	assign wr_data   = {n, gray_s1};
	assign top       = row1_s1 ? gray_s1 : o;
	assign newcol    = {top, n, gray_s1};

	// pixel codes use the window after the shift
	assign code_a = lbp_code(c1_s1 ? newcol : win1_q, win2_q, newcol);
	assign code_b = lbp_code(win2_q, newcol, win2_q);

	// drain code: bottom row reflects onto the older row
	assign dright    = {o, n, o};
	assign dcenter16 = d0_s1 ? col0_q : dcur_q;
	assign dcenter   = {dcenter16[15:8], dcenter16[7:0], dcenter16[15:8]};
	assign dleft     = d0_s1 ? dright : {dprev_q[15:8], dprev_q[7:0], dprev_q[15:8]};
	assign code_d    = lbp_code(dleft, dcenter, dright);

	// window columns
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win0_q <= '0;
			win1_q <= '0;
			win2_q <= '0;
		end else if (cfg_we || (fire && drain_s1 && last_s1)) begin
			win0_q <= '0;
			win1_q <= '0;
			win2_q <= '0;
		end else if (wr_en) begin
			win0_q <= win1_q;
			win1_q <= win2_q;
			win2_q <= newcol;
		end
	end

	// drain columns and saved first column of the newest row
	always_ff @(posedge clk) begin
		if (fire && drain_s1) begin
			dprev_q <= dcenter16;
			dcur_q  <= line_word;
		end
		if (wr_en && c0_s1) begin
			col0_q <= wr_data;
		end
	end

	// results into the queue
	always_comb begin
		push.v0 = fire && (drain_s1 || emit_s1);
		push.v1 = fire && !drain_s1 && emit_s1 && last_s1;
		if (drain_s1) begin
			push.r0 = '{eob: 1'b1, eoi: last_s1, code: code_d};
		end else begin
			push.r0 = '{eob: !last_s1, eoi: 1'b0, code: code_a};
		end
		push.r1 = '{eob: 1'b1, eoi: 1'b0, code: code_b};
	end

	lbp_out_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room     (room),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data (head)
	);

	assign m_tdata = head.code;
	assign m_tlast = head.eoi;
	assign m_tuser = head.eob;

endmodule
